// ----- src/lzssr_pkg.sv -----
package lzssr_pkg;

   localparam int RING_DEPTH = 4096;
   localparam int MAX_MATCH  = 18;
   localparam int MIN_MATCH  = 3;

   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int FILL_W = $clog2(RING_DEPTH + 1);
   localparam int CNT_W  = $clog2(MAX_MATCH);

   localparam logic [PTR_W-1:0] WP_RESET = PTR_W'(RING_DEPTH - MAX_MATCH);
   localparam logic [7:0]       FLAG_MARK = 8'hff;

   typedef struct packed {
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic [7:0]       wr_data;
   } ring_req_type;

endpackage

// ----- src/lzssr_ring.sv -----
module lzssr_ring (
   input  logic                   clock,
   input  logic                   reset,
   input  lzssr_pkg::ring_req_type ring_req,
   output logic [7:0]             rd_data
);

   logic [7:0]                    mem [lzssr_pkg::RING_DEPTH];
   logic [7:0]                    rd_data_ff;
   logic                          rd_valid_ff;
   logic                          rd_valid_in;
   logic [lzssr_pkg::FILL_W-1:0]  fill_ff;
   logic [lzssr_pkg::FILL_W-1:0]  fill_in;
   logic [lzssr_pkg::PTR_W-1:0]   rd_offset;

   // writes run in order from the reset pointer, so an entry holds data
   // once its distance from that pointer is below the number of writes
   always_comb begin
      rd_offset   = ring_req.rd_addr - lzssr_pkg::WP_RESET;
      rd_valid_in = {1'b0, rd_offset} < fill_ff;
      fill_in     = fill_ff;
      if (ring_req.wr_en && fill_ff != lzssr_pkg::FILL_W'(lzssr_pkg::RING_DEPTH)) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_req.wr_en) begin
         mem[ring_req.wr_addr] <= ring_req.wr_data;
      end
      if (ring_req.rd_en) begin
         rd_data_ff <= mem[ring_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (ring_req.rd_en) begin
            rd_valid_ff <= rd_valid_in;
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : 8'h00;

endmodule

// ----- src/lzss_ring_decompressor.sv -----
// a literal or pass-through byte is in the output register in the cycle after its beat
// a pair's high byte yields 3 to 18 bytes, each through a ring read and then a write-back
// throughput: one input beat per cycle while no copy runs and the output register drains
// reset is synchronous; the ring is not swept: unwritten entries read as zero via a fill count
// after reset the block accepts input at once
module lzss_ring_decompressor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_WRITE
   } state_type;

   state_type                     state_ff, state_in;
   logic                          comp_ff, comp_in;
   logic [lzssr_pkg::PTR_W-1:0]   wp_ff, wp_in;
   logic [lzssr_pkg::PTR_W-1:0]   src_ff, src_in;
   logic [lzssr_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [15:0]                   flag_ff, flag_in;
   logic [7:0]                    pending_ff, pending_in;
   logic                          awaiting_ff, awaiting_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    rsp_byte_ff, rsp_byte_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          out_free;
   logic                          req_fire;
   logic                          out_load;
   logic [11:0]                   pos_full;
   lzssr_pkg::ring_req_type       ring_req;
   logic [7:0]                    ring_rd_data;

   lzssr_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .ring_req(ring_req),
      .rd_data (ring_rd_data)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      req_ready    = (state_ff == S_IDLE) && out_free;
      req_fire     = req_valid && req_ready;
      pos_full     = {req_in_byte[7:4], pending_ff};
      out_load     = 1'b0;

      state_in     = state_ff;
      comp_in      = comp_ff;
      wp_in        = wp_ff;
      src_in       = src_ff;
      cnt_in       = cnt_ff;
      flag_in      = flag_ff;
      pending_in   = pending_ff;
      awaiting_in  = awaiting_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      ring_req     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (!comp_ff) begin
                  out_load    = 1'b1;
                  rsp_byte_in = req_in_byte;
                  rsp_last_in = 1'b1;
               end else if (awaiting_ff) begin
                  src_in      = pos_full[lzssr_pkg::PTR_W-1:0];
                  cnt_in      = lzssr_pkg::CNT_W'(req_in_byte[3:0])
                              + lzssr_pkg::CNT_W'(lzssr_pkg::MIN_MATCH - 1);
                  awaiting_in = 1'b0;
                  pending_in  = 8'h00;
                  flag_in     = flag_ff >> 1;
                  state_in    = S_READ;
               end else if (!flag_ff[8]) begin
                  flag_in = {lzssr_pkg::FLAG_MARK, req_in_byte};
               end else if (flag_ff[0]) begin
                  ring_req.wr_en   = 1'b1;
                  ring_req.wr_addr = wp_ff;
                  ring_req.wr_data = req_in_byte;
                  wp_in            = wp_ff + 1'b1;
                  out_load         = 1'b1;
                  rsp_byte_in      = req_in_byte;
                  rsp_last_in      = 1'b1;
                  flag_in          = flag_ff >> 1;
               end else begin
                  pending_in  = req_in_byte;
                  awaiting_in = 1'b1;
               end
            end
         end
         S_READ: begin
            ring_req.rd_en   = 1'b1;
            ring_req.rd_addr = src_ff;
            state_in         = S_WRITE;
         end
         S_WRITE: begin
            if (out_free) begin
               ring_req.wr_en   = 1'b1;
               ring_req.wr_addr = wp_ff;
               ring_req.wr_data = ring_rd_data;
               wp_in            = wp_ff + 1'b1;
               src_in           = src_ff + 1'b1;
               out_load         = 1'b1;
               rsp_byte_in      = ring_rd_data;
               rsp_last_in      = (cnt_ff == '0);
               if (cnt_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff - 1'b1;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
      if (csr_wr_en) begin
         comp_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         comp_ff      <= 1'b1;
         wp_ff        <= lzssr_pkg::WP_RESET;
         flag_ff      <= '0;
         pending_ff   <= '0;
         awaiting_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         comp_ff      <= comp_in;
         wp_ff        <= wp_in;
         flag_ff      <= flag_in;
         pending_ff   <= pending_in;
         awaiting_ff  <= awaiting_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff      <= src_in;
      cnt_ff      <= cnt_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // a pair is only pending inside a flag group
   a_pair_in_group: assert property (@(posedge clock) disable iff (reset)
      awaiting_ff |-> flag_ff[8])
      else $error("pair pending with no flag group");

   // every ring write also produces an output beat
   a_write_outputs: assert property (@(posedge clock) disable iff (reset)
      ring_req.wr_en |-> out_load)
      else $error("ring write without output beat");

   // write pointer only moves with a ring write
   a_wp_hold: assert property (@(posedge clock) disable iff (reset)
      !ring_req.wr_en |=> $stable(wp_ff))
      else $error("write pointer moved without a write");

   // the final copy byte is marked and ends the run
   a_copy_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && out_free && cnt_ff == '0)
      |=> (state_ff == S_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("copy run did not end cleanly");

   // no read and write of the ring in the same cycle
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ring_req.rd_en && ring_req.wr_en))
      else $error("ring read and write collide");

endmodule

// ----- sim/lzss_ring_decompressor_tb.sv -----
`timescale 1ns / 100ps

module lzss_ring_decompressor_tb;

   localparam logic MODE_PASS = 1'b0;
   localparam logic MODE_LZSS = 1'b1;
   localparam int   NUM_DIR   = 24;
   localparam int   DRAIN_CYC = 2 * lzssr_pkg::MAX_MATCH + 8;
   localparam int   LIMIT     = 600000;

   typedef struct packed {
      logic       mode;
      logic [7:0] data;
      logic       typed;
      logic [4:0] n;
      logic [7:0] val;
   } row_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   // decoder state mirrored by the predictor
   logic [7:0]                  hist [lzssr_pkg::RING_DEPTH];
   logic [lzssr_pkg::PTR_W-1:0] wptr;
   logic [15:0]                 flag_sr;
   logic [7:0]                  pend_low;
   logic                        awaiting;
   logic                        lz_on;

   beat_type    expected_beats [$];
   beat_type    head;
   logic [7:0]  planned_high = 8'h00;
   logic        no_idle = 1'b0;
   int unsigned errors = 0;
   int unsigned cycles = 0;

   row_type dir_rows [NUM_DIR] = '{
      '{MODE_LZSS, 8'hf8, 1'b1, 5'd0,  8'h00},
      '{MODE_LZSS, 8'h00, 1'b1, 5'd0,  8'h00},
      '{MODE_LZSS, 8'h0f, 1'b1, 5'd18, 8'h00},
      '{MODE_LZSS, 8'hff, 1'b1, 5'd0,  8'h00},
      '{MODE_LZSS, 8'hf0, 1'b1, 5'd3,  8'h00},
      '{MODE_LZSS, 8'hee, 1'b1, 5'd0,  8'h00},
      '{MODE_PASS, 8'h00, 1'b1, 5'd1,  8'h00},
      '{MODE_PASS, 8'hff, 1'b1, 5'd1,  8'hff},
      '{MODE_PASS, 8'ha5, 1'b1, 5'd1,  8'ha5},
      '{MODE_LZSS, 8'h05, 1'b1, 5'd8,  8'h00},
      '{MODE_LZSS, 8'h00, 1'b1, 5'd1,  8'h00},
      '{MODE_LZSS, 8'hff, 1'b1, 5'd1,  8'hff},
      '{MODE_LZSS, 8'h80, 1'b1, 5'd1,  8'h80},
      '{MODE_LZSS, 8'h01, 1'b1, 5'd1,  8'h01},
      '{MODE_LZSS, 8'h55, 1'b1, 5'd1,  8'h55},
      '{MODE_LZSS, 8'h00, 1'b1, 5'd0,  8'h00},
      '{MODE_LZSS, 8'h0f, 1'b0, 5'd0,  8'h00},
      '{MODE_LZSS, 8'h0f, 1'b0, 5'd0,  8'h00},
      '{MODE_LZSS, 8'h0c, 1'b0, 5'd0,  8'h00},
      '{MODE_LZSS, 8'h01, 1'b0, 5'd0,  8'h00},
      '{MODE_LZSS, 8'h34, 1'b0, 5'd0,  8'h00},
      '{MODE_LZSS, 8'ha2, 1'b0, 5'd0,  8'h00},
      '{MODE_LZSS, 8'hff, 1'b0, 5'd0,  8'h00},
      '{MODE_LZSS, 8'hff, 1'b0, 5'd0,  8'h00}
   };

   lzss_ring_decompressor u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 28);
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            $display("%0t unexpected beat: expected none, actual out_byte=%02h last=%0b",
                     $time, rsp_out_byte, rsp_last_of_run);
            errors++;
         end else begin
            head = expected_beats.pop_front();
            if (rsp_out_byte !== head.out_byte) begin
               $display("%0t out_byte mismatch: expected %02h, actual %02h",
                        $time, head.out_byte, rsp_out_byte);
               errors++;
            end
            if (rsp_last_of_run !== head.last) begin
               $display("%0t last_of_run mismatch: expected %0b, actual %0b",
                        $time, head.last, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   task automatic clear_history();
      foreach (hist[i]) hist[i] = 8'h00;
      wptr     = lzssr_pkg::WP_RESET;
      flag_sr  = 16'h0000;
      pend_low = 8'h00;
      awaiting = 1'b0;
      lz_on    = MODE_LZSS;
   endtask

   task automatic push_beat(input logic [7:0] b, input logic last, input logic en);
      if (en) expected_beats.push_back('{out_byte: b, last: last});
   endtask

   task automatic store_hist(input logic [7:0] b);
      hist[wptr] = b;
      wptr       = wptr + 1'b1;
   endtask

   // expected output bytes for one compressed byte
   task automatic decode_byte(input logic [7:0] b, input logic en);
      logic [lzssr_pkg::PTR_W-1:0] pos;
      int                          len;
      logic [7:0]                  c;
      if (lz_on == MODE_PASS) begin
         push_beat(b, 1'b1, en);
      end else if (awaiting) begin
         pos = {b[7:4], pend_low};
         len = int'(b[3:0]) + lzssr_pkg::MIN_MATCH;
         for (int i = 0; i < len; i++) begin
            c = hist[pos + lzssr_pkg::PTR_W'(i)];
            store_hist(c);
            push_beat(c, i == len - 1, en);
         end
         awaiting = 1'b0;
         pend_low = 8'h00;
         flag_sr  = flag_sr >> 1;
      end else if (!flag_sr[8]) begin
         flag_sr = {lzssr_pkg::FLAG_MARK, b};
      end else if (flag_sr[0]) begin
         store_hist(b);
         push_beat(b, 1'b1, en);
         flag_sr = flag_sr >> 1;
      end else begin
         pend_low = b;
         awaiting = 1'b1;
      end
   endtask

   task automatic send_byte(input row_type r);
      logic hit;
      hit = 1'b0;
      while (!no_idle && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= r.data;
      while (!hit) begin
         @(negedge clock);
         if (req_ready) begin
            hit = 1'b1;
            decode_byte(r.data, !r.typed);
            for (int i = 0; i < int'(r.n); i++)
               push_beat(r.val, i == int'(r.n) - 1, r.typed);
         end
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (expected_beats.size() != 0) @(posedge clock);
   endtask

   task automatic set_mode(input logic m);
      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYC) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      lz_on = m;
   endtask

   // mostly well-formed groups steered by the predicted decoder state, some noise
   task automatic run_random(input int n_items, input int pause_at);
      row_type                     r;
      logic [lzssr_pkg::PTR_W-1:0] pos;
      r = '0;
      for (int k = 0; k < n_items; k++) begin
         if (k == pause_at) begin
            req_valid <= 1'b0;
            wait_drained();
         end
         if (lz_on == MODE_PASS || $urandom_range(0, 99) < 8) begin
            r.data = 8'($urandom_range(0, 255));
         end else if (awaiting) begin
            r.data = planned_high;
         end else if (!flag_sr[8] || flag_sr[0]) begin
            r.data = 8'($urandom_range(0, 255));
         end else begin
            if ($urandom_range(0, 99) < 65)
               pos = wptr - lzssr_pkg::PTR_W'($urandom_range(1, 64));
            else
               pos = lzssr_pkg::PTR_W'($urandom);
            r.data       = pos[7:0];
            planned_high = {pos[11:8], 4'($urandom_range(0, 15))};
         end
         send_byte(r);
      end
   endtask

   initial begin
      clear_history();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].mode != lz_on) set_mode(dir_rows[i].mode);
         send_byte(dir_rows[i]);
      end

      set_mode(MODE_LZSS);
      run_random(60, -1);
      set_mode(MODE_PASS);
      run_random(50, -1);
      set_mode(MODE_LZSS);
      no_idle = 1'b1;
      run_random(70, -1);
      no_idle = 1'b0;
      set_mode(MODE_LZSS);
      run_random(60, 30);
      set_mode(MODE_PASS);
      run_random(50, -1);
      set_mode(MODE_LZSS);
      run_random(70, -1);

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYC) @(posedge clock);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/lzssr_pkg.sv
src/lzssr_ring.sv
src/lzss_ring_decompressor.sv
sim/lzss_ring_decompressor_tb.sv
